[rtl/core/verlet_particle_step_top_assert.svh]
// Assertion macros shared by the block's modules
`ifndef VERLET_PARTICLE_STEP_TOP_ASSERT_SVH
`define VERLET_PARTICLE_STEP_TOP_ASSERT_SVH

// Implication checked on every rising edge outside reset
`define VPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define VPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/vps_pkg.sv]
// ----------------------------------------------------------------------------
// vps_pkg
// Types and constants of the Verlet particle step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package vps_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned WideW  = 64;
  localparam int unsigned DtW    = 31;
  localparam int unsigned ThrW   = 7;
  localparam int unsigned IdxW   = 8;

  localparam logic [DtW-1:0]  DtReset  = 31'd655;
  localparam logic [ThrW-1:0] ThrReset = 7'd35;

  localparam logic [IdxW-1:0] RegDtSquared = 8'd0;
  localparam logic [IdxW-1:0] RegRetireThr = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NEXT,
    ST_SQ_GO,
    ST_SQ,
    ST_SQRT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic               start;
    logic [WideW-1:0]   mcand;
    logic [DataW-1:0]   mplier;
  } mul_req_t;

endpackage

[rtl/core/vps_if.sv]
// ----------------------------------------------------------------------------
// vps_if
// Valid/ready channels: particle input, result output, register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface vps_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] prev_x, prev_y, prev_z;
  logic signed [31:0] acc_x, acc_y, acc_z;
  logic signed [31:0] life_in;
  logic group_last;
  modport source (output valid, pos_x, pos_y, pos_z, prev_x, prev_y, prev_z,
                  acc_x, acc_y, acc_z, life_in, group_last, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, prev_x, prev_y, prev_z,
                acc_x, acc_y, acc_z, life_in, group_last, output ready);
endinterface

interface vps_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] next_x, next_y, next_z;
  logic signed [31:0] life_out;
  logic dead;
  logic group_done;
  logic retire;
  modport source (output valid, next_x, next_y, next_z, life_out, dead,
                  group_done, retire, input ready);
  modport sink (input valid, next_x, next_y, next_z, life_out, dead,
                group_done, retire, output ready);
endinterface

interface vps_cfg_if;
  logic valid;
  logic ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/verlet_particle_step_top.sv]
// ----------------------------------------------------------------------------
// verlet_particle_step_top
// Position Verlet step with life tracking and group retirement.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one particle per transfer (position, previous position,
//            acceleration, life, group_last), signed Q16.16.
//   out_o  : one result per particle: next position, life_out, dead,
//            group_done and retire. Held until the sink takes it.
//   cfg_i  : register writes, index 0 dt_squared, 1 retire_threshold.
//            Always ready; other indexes are dropped.
// Timing: acc*dt_squared in three serial multiplier lanes, then the next
//   position (ST_NEXT), a start and the squaring in the same lanes, a serial
//   square root, and the life and group counter update (ST_FIN). The next
//   item is taken the cycle after the result is loaded; one item is in flight
//   at a time.
// Reset: registers return to dt_squared 655, threshold 35, count 0.
// Stall: a finished result waits in the output register; the next item is
//   accepted and worked on, and stops at the final step until the output
//   register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "verlet_particle_step_top_assert.svh"
module verlet_particle_step_top #(
  parameter int unsigned GROUP_SIZE = 40
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  vps_in_if.sink   in_i,
  vps_out_if.source out_o,
  vps_cfg_if.sink  cfg_i
);
  localparam int unsigned CntW = $clog2(GROUP_SIZE + 1);
  localparam int unsigned ThrW = vps_pkg::ThrW;

  vps_pkg::state_e state_q, state_d;

  // configuration registers
  logic [vps_pkg::DtW-1:0]  dt_q;
  logic [vps_pkg::ThrW-1:0] thr_q;

  // captured item
  logic signed [31:0] pos_q [3];
  logic signed [31:0] prev_q [3];
  logic signed [31:0] life_q;
  logic               last_q;

  // per-lane results
  logic signed [31:0] next_q [3];
  logic [31:0]        mag_q [3];
  logic signed [31:0] next_w [3];
  logic [31:0]        mag_w [3];

  vps_pkg::mul_req_t  mreq [3];
  logic [2:0]         mdone;
  logic [63:0]        prod [3];

  logic               in_xfer, out_xfer, fin_ok;
  logic               sqrt_start, sqrt_done;
  logic [63:0]        sumsq;
  logic [31:0]        root;
  logic [CntW-1:0]    cnt_q;

  // output register
  logic               ovalid_q;
  logic signed [31:0] onx_q, ony_q, onz_q, olife_q;
  logic               odead_q, odone_q, oret_q;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = ovalid_q && out_o.ready;
  assign fin_ok   = !ovalid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vps_pkg::ST_IDLE:  if (in_i.valid) state_d = vps_pkg::ST_MUL;
      vps_pkg::ST_MUL:   if (mdone[0]) state_d = vps_pkg::ST_NEXT;
      vps_pkg::ST_NEXT:  state_d = vps_pkg::ST_SQ_GO;
      vps_pkg::ST_SQ_GO: state_d = vps_pkg::ST_SQ;
      vps_pkg::ST_SQ:    if (mdone[0]) state_d = vps_pkg::ST_SQRT;
      vps_pkg::ST_SQRT:  if (sqrt_done) state_d = vps_pkg::ST_FIN;
      vps_pkg::ST_FIN:   if (fin_ok) state_d = vps_pkg::ST_IDLE;
      default:           state_d = vps_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready = 1'b0;
    sqrt_start = 1'b0;
    for (int a = 0; a < 3; a++) begin
      mreq[a].start  = 1'b0;
      mreq[a].mcand  = {32'b0, mag_q[a]};
      mreq[a].mplier = mag_q[a];
    end
    unique case (state_q)
      vps_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        // acc sign-extended, dt zero-extended; product kept mod 2^64
        mreq[0].mcand  = {{32{in_i.acc_x[31]}}, in_i.acc_x};
        mreq[1].mcand  = {{32{in_i.acc_y[31]}}, in_i.acc_y};
        mreq[2].mcand  = {{32{in_i.acc_z[31]}}, in_i.acc_z};
        for (int a = 0; a < 3; a++) begin
          mreq[a].start  = in_i.valid;
          mreq[a].mplier = {1'b0, dt_q};
        end
      end
      vps_pkg::ST_SQ_GO: begin
        for (int a = 0; a < 3; a++) mreq[a].start = 1'b1;
      end
      vps_pkg::ST_SQ:    sqrt_start = mdone[0];
      default: ;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      logic [63:0]        rnd;
      logic signed [49:0] raw;
      logic signed [33:0] dlt;

      vps_serial_mul u_mul (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .req_i  (mreq[g]),
        .done_o (mdone[g]),
        .prod_o (prod[g])
      );

      // round half up to Q16.16, then 2*pos - prev + term, saturated
      assign rnd = prod[g] + 64'd32768;
      always_comb begin
        raw = 50'(signed'(rnd[63:16])) + (50'(pos_q[g]) <<< 1) - 50'(prev_q[g]);
        if (raw > 50'sd2147483647)       next_w[g] = 32'sh7FFFFFFF;
        else if (raw < -50'sd2147483648) next_w[g] = 32'sh80000000;
        else                             next_w[g] = raw[31:0];
        dlt = 34'(pos_q[g]) - 34'(next_w[g]);
        if (dlt[33])          dlt = -dlt;
        if (dlt[32])          mag_w[g] = 32'hFFFFFFFF;
        else                  mag_w[g] = dlt[31:0];
      end
    end
  endgenerate

  // saturating sum of the three squares
  always_comb begin
    logic [65:0] s;
    s = 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]);
    sumsq = (s[65:64] != 2'b00) ? 64'hFFFFFFFFFFFFFFFF : s[63:0];
  end

  vps_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     (sumsq),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // life update and group counting
  logic signed [33:0] life_raw;
  logic signed [31:0] life_w;
  logic               dead_w;
  logic [CntW-1:0]    cnt_inc;
  always_comb begin
    life_raw = 34'(life_q) - 34'({2'b00, root});
    if (life_raw > 34'sd2147483647)       life_w = 32'sh7FFFFFFF;
    else if (life_raw < -34'sd2147483648) life_w = 32'sh80000000;
    else                                  life_w = life_raw[31:0];
    dead_w  = (life_w <= 32'sd0);
    cnt_inc = (dead_w && (cnt_q < CntW'(GROUP_SIZE))) ? cnt_q + CntW'(1) : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vps_pkg::ST_IDLE;
      dt_q     <= vps_pkg::DtReset;
      thr_q    <= vps_pkg::ThrReset;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.index == vps_pkg::RegDtSquared)
        dt_q <= cfg_i.data[vps_pkg::DtW-1:0];
      if (cfg_i.valid && cfg_i.index == vps_pkg::RegRetireThr)
        thr_q <= cfg_i.data[vps_pkg::ThrW-1:0];
      if (state_q == vps_pkg::ST_FIN && fin_ok) begin
        ovalid_q <= 1'b1;
        cnt_q    <= last_q ? '0 : cnt_inc;
      end else if (out_xfer) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pos_q[0]  <= in_i.pos_x;  pos_q[1]  <= in_i.pos_y;  pos_q[2]  <= in_i.pos_z;
      prev_q[0] <= in_i.prev_x; prev_q[1] <= in_i.prev_y; prev_q[2] <= in_i.prev_z;
      life_q    <= in_i.life_in;
      last_q    <= in_i.group_last;
    end
    if (state_q == vps_pkg::ST_NEXT) begin
      for (int a = 0; a < 3; a++) begin
        next_q[a] <= next_w[a];
        mag_q[a]  <= mag_w[a];
      end
    end
    if (state_q == vps_pkg::ST_FIN && fin_ok) begin
      onx_q   <= next_q[0];
      ony_q   <= next_q[1];
      onz_q   <= next_q[2];
      olife_q <= life_w;
      odead_q <= dead_w;
      odone_q <= last_q;
      oret_q  <= last_q && (ThrW'(cnt_inc) > thr_q);
    end
  end

  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = ovalid_q;
  assign out_o.next_x     = onx_q;
  assign out_o.next_y     = ony_q;
  assign out_o.next_z     = onz_q;
  assign out_o.life_out   = olife_q;
  assign out_o.dead       = odead_q;
  assign out_o.group_done = odone_q;
  assign out_o.retire     = oret_q;

  `VPS_ASSERT_NEXT(a_accept_mul, in_xfer, state_q == vps_pkg::ST_MUL, "accept did not start")
  `VPS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(GROUP_SIZE), "dead count over group size")
  `VPS_ASSERT_IMP(a_retire_end, ovalid_q && !odone_q, !oret_q, "retire outside group end")
  `VPS_ASSERT_IMP(a_lanes_sync, 1'b1, mdone == 3'b000 || mdone == 3'b111,
                  "multiplier lanes out of step")
endmodule

[rtl/core/vps_serial_mul.sv]
// ----------------------------------------------------------------------------
// vps_serial_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, mod 2^64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vps_serial_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vps_pkg::mul_req_t          req_i,
  output logic                       done_o,
  output logic [vps_pkg::WideW-1:0]  prod_o
);
  logic                       busy_q, busy_d;
  logic                       done_q;
  logic [4:0]                 cnt_q, cnt_d;
  logic [vps_pkg::WideW-1:0]  a_q, a_d, p_q, p_d;
  logic [vps_pkg::DataW-1:0]  b_q, b_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = req_i.mcand;
      b_d    = req_i.mplier;
      p_d    = '0;
    end else if (busy_q) begin
      p_d   = p_q + (b_q[0] ? a_q : '0);
      a_d   = {a_q[vps_pkg::WideW-2:0], 1'b0};
      b_d   = {1'b0, b_q[vps_pkg::DataW-1:1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      // product is final the cycle after the last step
      done_q <= busy_q && (cnt_q == 5'd31);
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;
endmodule

[rtl/core/vps_isqrt.sv]
// ----------------------------------------------------------------------------
// vps_isqrt
// Digit-by-digit floor square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "verlet_particle_step_top_assert.svh"
module vps_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vps_pkg::WideW-1:0]  v_i,
  output logic                       done_o,
  output logic [vps_pkg::DataW-1:0]  root_o
);
  logic                       busy_q, busy_d;
  logic [vps_pkg::WideW-1:0]  v_q, v_d, res_q, res_d, bit_q, bit_d, trial;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = v_i;
      res_d  = '0;
      bit_d  = {2'b01, {(vps_pkg::WideW-2){1'b0}}};
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
  end

  assign done_o = busy_q && bit_q[0];
  assign root_o = res_q[vps_pkg::DataW-1:0];

  `VPS_ASSERT_IMP(a_bit_onehot, busy_q, $onehot(bit_q), "sqrt bit not one-hot")
  `VPS_ASSERT_NEXT(a_done_idle, done_o && !start_i, !busy_q, "sqrt busy after done")
  `VPS_ASSERT_IMP(a_idle_bit, !busy_q, bit_q == '0, "sqrt bit left over while idle")
endmodule
